@@ hdl/imlt_pkg.sv @@
// ----------------------------------------------------------------------------
// IRC message line tokenizer package
// Shared item types, character codes, field kind codes and parameter limits.
// ----------------------------------------------------------------------------
package imlt_pkg;

  localparam int MaxParams = 15;
  localparam int CountCap  = (MaxParams > 15) ? 15 : ((MaxParams < 1) ? 1 : MaxParams);

  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7A;
  localparam logic [7:0] CaseStep = 8'h20;

  typedef enum logic [2:0] {
    KIND_SEP    = 3'd0,
    KIND_PREFIX = 3'd1,
    KIND_CMD    = 3'd2,
    KIND_MIDDLE = 3'd3,
    KIND_TRAIL  = 3'd4
  } field_kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] field_kind;
    logic       is_content;
    logic       field_first;
    logic [3:0] param_index;
    logic       last_of_line;
    logic [3:0] param_count;
    logic       malformed;
    logic       params_overflow;
  } out_item_t;

endpackage

@@ hdl/imlt_stream_if.sv @@
// ----------------------------------------------------------------------------
// IRC message line tokenizer channels
// Valid/ready channels for input bytes and for tagged result items.
// ----------------------------------------------------------------------------
interface imlt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       line_end;

  modport source (output valid, in_byte, line_end, input ready);
  modport sink (input valid, in_byte, line_end, output ready);
endinterface

interface imlt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] field_kind;
  logic       is_content;
  logic       field_first;
  logic [3:0] param_index;
  logic       last_of_line;
  logic [3:0] param_count;
  logic       malformed;
  logic       params_overflow;

  modport source (output valid, out_byte, field_kind, is_content, field_first,
                  param_index, last_of_line, param_count, malformed,
                  params_overflow, input ready);
  modport sink (input valid, out_byte, field_kind, is_content, field_first,
                param_index, last_of_line, param_count, malformed,
                params_overflow, output ready);
endinterface

@@ hdl/imlt_in_stage.sv @@
// ----------------------------------------------------------------------------
// IRC tokenizer input register
// Holds one accepted input item until the parse core takes it.
// ----------------------------------------------------------------------------
module imlt_in_stage
  import imlt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_item_t item_i,
  output logic     valid_o,
  input  logic     take_i,
  output in_item_t item_o
);

  logic     valid_q;
  in_item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

@@ hdl/imlt_parse_core.sv @@
// ----------------------------------------------------------------------------
// IRC tokenizer parse core
// Phase machine that tags one byte per cycle while the output is not stalled and holds the result register.
// ----------------------------------------------------------------------------
module imlt_parse_core
  import imlt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  in_item_t  item_i,
  output logic      take_o,
  output logic      valid_o,
  input  logic      ready_i,
  output out_item_t result_o
);

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_PREFIX = 3'd1,
    PH_PRECMD = 3'd2,
    PH_CMD    = 3'd3,
    PH_SEP    = 3'd4,
    PH_MIDDLE = 3'd5,
    PH_TRAIL  = 3'd6
  } phase_e;

  localparam logic [3:0] Cap = 4'(CountCap);

  phase_e      phase_q, phase_d;
  logic [3:0]  count_q, count_d;
  logic        has_q, has_d;
  logic        ovf_q, ovf_d;
  logic        valid_q;
  out_item_t   result_q, result_d;
  logic        fire;

  assign take_o   = !valid_q || ready_i;
  assign fire     = take_o && valid_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_comb begin
    logic [7:0]  c;
    logic        start_p;
    logic        cmd_b;
    logic        mid_b;
    logic        trl_b;
    field_kind_e kind;
    c       = item_i.in_byte;
    phase_d = phase_q;
    count_d = count_q;
    has_d   = has_q;
    ovf_d   = ovf_q;
    start_p = 1'b0;
    cmd_b   = 1'b0;
    mid_b   = 1'b0;
    trl_b   = 1'b0;
    kind    = KIND_SEP;
    result_d = '0;
    result_d.out_byte = c;

    unique case (phase_q)
      PH_START: begin
        if (c == ChColon) begin
          kind    = KIND_PREFIX;
          phase_d = PH_PREFIX;
          has_d   = 1'b0;
        end else if (c == ChSpace) begin
          phase_d = PH_PRECMD;
        end else begin
          has_d = 1'b0;
          cmd_b = 1'b1;
        end
      end
      PH_PREFIX: begin
        if (c == ChSpace) begin
          phase_d = PH_PRECMD;
        end else begin
          kind                 = KIND_PREFIX;
          result_d.is_content  = 1'b1;
          result_d.field_first = !has_q;
          has_d                = 1'b1;
        end
      end
      PH_PRECMD: begin
        if (c != ChSpace) begin
          has_d = 1'b0;
          cmd_b = 1'b1;
        end
      end
      PH_CMD: begin
        if (c == ChSpace) begin
          phase_d = PH_SEP;
        end else begin
          cmd_b = 1'b1;
        end
      end
      PH_SEP: begin
        if (c == ChColon) begin
          start_p = 1'b1;
          phase_d = PH_TRAIL;
          kind    = KIND_TRAIL;
        end else if (c != ChSpace) begin
          start_p = 1'b1;
          mid_b   = 1'b1;
        end
      end
      PH_MIDDLE: begin
        if (c == ChSpace) begin
          phase_d = PH_SEP;
        end else begin
          mid_b = 1'b1;
        end
      end
      default: begin
        trl_b = 1'b1;
      end
    endcase

    if (start_p) begin
      if (32'(count_q) >= MaxParams) begin
        ovf_d = 1'b1;
      end
      if (count_q < Cap) begin
        count_d = count_q + 4'd1;
      end
      has_d = 1'b0;
    end

    if (cmd_b || mid_b || trl_b) begin
      result_d.is_content  = 1'b1;
      result_d.field_first = !has_d;
      has_d                = 1'b1;
      if (cmd_b) begin
        phase_d = PH_CMD;
        kind    = KIND_CMD;
        if (c >= ChLowerA && c <= ChLowerZ) begin
          result_d.out_byte = c - CaseStep;
        end
      end else begin
        phase_d = mid_b ? PH_MIDDLE : PH_TRAIL;
        kind    = mid_b ? KIND_MIDDLE : KIND_TRAIL;
      end
    end

    if (kind == KIND_MIDDLE || kind == KIND_TRAIL) begin
      result_d.param_index = (count_d == 4'd0) ? 4'd0 : count_d - 4'd1;
    end

    result_d.field_kind      = kind;
    result_d.last_of_line    = item_i.line_end;
    result_d.param_count     = count_d;
    result_d.malformed       = item_i.line_end && (phase_d == PH_PREFIX);
    result_d.params_overflow = ovf_d;

    if (item_i.line_end) begin
      phase_d = PH_START;
      count_d = 4'd0;
      has_d   = 1'b0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      count_q <= 4'd0;
      has_q   <= 1'b0;
      ovf_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        valid_q <= valid_i;
      end
      if (fire) begin
        phase_q <= phase_d;
        count_q <= count_d;
        has_q   <= has_d;
        ovf_q   <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result_d;
    end
  end

endmodule

@@ hdl/irc_message_line_tokenizer.sv @@
// ----------------------------------------------------------------------------
// IRC message line tokenizer
// Tags each byte of a message line as prefix, command, parameter or separator.
// ----------------------------------------------------------------------------
//   Channel  Dir  Contents
//   in_i     in   in_byte, line_end
//   out_o    out  out_byte, field_kind, is_content, field_first, param_index,
//                 last_of_line, param_count, malformed, params_overflow
//
// One item is accepted per cycle while the output is not stalled; its result
// reaches out_o after passing the input register and the result register of
// the parse core, whose phase state is updated once per item.
// Reset returns the phase machine to line start with all counters clear.
// A stall on the output holds the result and backs up into the input stage.
module irc_message_line_tokenizer
  import imlt_pkg::*;
(
  input logic   clk_i,
  input logic   rst_ni,
  imlt_in_if.sink    in_i,
  imlt_out_if.source out_o
);

  in_item_t  in_item;
  in_item_t  held_item;
  logic      held_valid;
  logic      take;
  out_item_t result;

  assign in_item.in_byte  = in_i.in_byte;
  assign in_item.line_end = in_i.line_end;

  imlt_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .item_i  (in_item),
    .valid_o (held_valid),
    .take_i  (take),
    .item_o  (held_item)
  );

  imlt_parse_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (held_valid),
    .item_i   (held_item),
    .take_o   (take),
    .valid_o  (out_o.valid),
    .ready_i  (out_o.ready),
    .result_o (result)
  );

  assign out_o.out_byte        = result.out_byte;
  assign out_o.field_kind      = result.field_kind;
  assign out_o.is_content      = result.is_content;
  assign out_o.field_first     = result.field_first;
  assign out_o.param_index     = result.param_index;
  assign out_o.last_of_line    = result.last_of_line;
  assign out_o.param_count     = result.param_count;
  assign out_o.malformed       = result.malformed;
  assign out_o.params_overflow = result.params_overflow;

endmodule

@@ hdl/imlt_checker.sv @@
// ----------------------------------------------------------------------------
// IRC tokenizer port checker
// Checks handshake holding and result consistency on the top level ports.
// ----------------------------------------------------------------------------
module imlt_checker
  import imlt_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic [2:0] field_kind_i,
  input logic       is_content_i,
  input logic       field_first_i,
  input logic [3:0] param_index_i,
  input logic       last_of_line_i,
  input logic [3:0] param_count_i,
  input logic       malformed_i
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Result item dropped while stalled.");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_byte_i) && $stable(field_kind_i))
    else $error("Stalled result item changed.");

  a_malformed_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && malformed_i |-> last_of_line_i && field_kind_i == KIND_PREFIX
      && param_count_i == 4'd0)
    else $error("Malformed flag away from an open prefix at line end.");

  a_first_content: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && field_first_i |-> is_content_i && field_kind_i != KIND_SEP)
    else $error("First-byte flag on a non-content byte.");

  a_index_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !(field_kind_i == KIND_MIDDLE || field_kind_i == KIND_TRAIL)
      |-> param_index_i == 4'd0)
    else $error("Parameter index set outside a parameter.");

endmodule

bind irc_message_line_tokenizer imlt_checker u_imlt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_byte_i     (out_o.out_byte),
  .field_kind_i   (out_o.field_kind),
  .is_content_i   (out_o.is_content),
  .field_first_i  (out_o.field_first),
  .param_index_i  (out_o.param_index),
  .last_of_line_i (out_o.last_of_line),
  .param_count_i  (out_o.param_count),
  .malformed_i    (out_o.malformed)
);

@@ verif/tb_irc_message_line_tokenizer.sv @@
// ----------------------------------------------------------------------------
// IRC message line tokenizer testbench
// Drives message lines byte by byte through the input channel, predicts the
// tag of every byte with an independent phase machine, and checks each
// result item in order. It uses directed lines, then random well-formed lines
// with noise and broken lines mixed in, bursty input and a patterned output
// stall, one long output hold-off and pauses until the block is drained.
// ----------------------------------------------------------------------------
module tb_irc_message_line_tokenizer;
  import imlt_pkg::*;

  typedef enum logic [2:0] {
    PH_START, PH_PREFIX, PH_PRECMD, PH_CMD, PH_SEP, PH_MIDDLE, PH_TRAIL
  } line_phase_e;

  typedef struct {
    in_item_t item;
    bit       drain;
  } pend_byte_t;

  logic clk_i;
  logic rst_ni;

  imlt_in_if  in_bus ();
  imlt_out_if out_bus ();

  irc_message_line_tokenizer i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  pend_byte_t  line_bytes[$];
  out_item_t   expected_tags[$];
  bit          drain_next;

  line_phase_e tok_phase;
  logic [3:0]  tok_params;
  bit          tok_field_has;
  bit          tok_overflow;

  int          accepted_bytes;
  int          lines_done;
  int          unclosed_lines;
  int          overflow_lines;
  int          drain_count;
  int          mismatch_count;
  int          burst_left;
  int          gap_left;
  int          hold_left;
  bit          hold_done;
  logic [7:0]  stall_cycle;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [3:0] param_slot();
    return (tok_params == 4'd0) ? 4'd0 : tok_params - 4'd1;
  endfunction

  function automatic void open_param();
    if (tok_params >= MaxParams) tok_overflow = 1'b1;
    if (tok_params < CountCap) tok_params = tok_params + 4'd1;
    tok_field_has = 1'b0;
  endfunction

  function automatic out_item_t tokenize_byte(input logic [7:0] ch, input logic last);
    out_item_t r;
    bit        cmd_b;
    bit        mid_b;
    bit        trail_b;
    r          = '0;
    r.out_byte = ch;
    r.field_kind = KIND_SEP;
    cmd_b      = 1'b0;
    mid_b      = 1'b0;
    trail_b    = 1'b0;
    case (tok_phase)
      PH_START: begin
        if (ch == ChColon) begin
          r.field_kind  = KIND_PREFIX;
          tok_phase     = PH_PREFIX;
          tok_field_has = 1'b0;
        end else if (ch == ChSpace) begin
          tok_phase = PH_PRECMD;
        end else begin
          tok_field_has = 1'b0;
          cmd_b         = 1'b1;
        end
      end
      PH_PREFIX: begin
        if (ch == ChSpace) begin
          tok_phase = PH_PRECMD;
        end else begin
          r.field_kind  = KIND_PREFIX;
          r.is_content  = 1'b1;
          r.field_first = !tok_field_has;
          tok_field_has = 1'b1;
        end
      end
      PH_PRECMD: begin
        if (ch != ChSpace) begin
          tok_field_has = 1'b0;
          cmd_b         = 1'b1;
        end
      end
      PH_CMD: begin
        if (ch == ChSpace) tok_phase = PH_SEP;
        else cmd_b = 1'b1;
      end
      PH_SEP: begin
        if (ch == ChColon) begin
          open_param();
          tok_phase     = PH_TRAIL;
          r.field_kind  = KIND_TRAIL;
          r.param_index = param_slot();
        end else if (ch != ChSpace) begin
          open_param();
          mid_b = 1'b1;
        end
      end
      PH_MIDDLE: begin
        if (ch == ChSpace) tok_phase = PH_SEP;
        else mid_b = 1'b1;
      end
      default: trail_b = 1'b1;
    endcase
    if (cmd_b || mid_b || trail_b) begin
      r.is_content  = 1'b1;
      r.field_first = !tok_field_has;
      tok_field_has = 1'b1;
      if (cmd_b) begin
        tok_phase    = PH_CMD;
        r.field_kind = KIND_CMD;
        if (ch >= ChLowerA && ch <= ChLowerZ) r.out_byte = ch - CaseStep;
      end else begin
        tok_phase     = mid_b ? PH_MIDDLE : PH_TRAIL;
        r.field_kind  = mid_b ? KIND_MIDDLE : KIND_TRAIL;
        r.param_index = param_slot();
      end
    end
    r.malformed       = last && (tok_phase == PH_PREFIX);
    r.last_of_line    = last;
    r.param_count     = tok_params;
    r.params_overflow = tok_overflow;
    if (last) begin
      tok_phase     = PH_START;
      tok_params    = 4'd0;
      tok_field_has = 1'b0;
      tok_overflow  = 1'b0;
    end
    return r;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last);
    pend_byte_t p;
    p.item.in_byte  = b;
    p.item.line_end = last;
    p.drain         = drain_next;
    drain_next      = 1'b0;
    line_bytes      = {line_bytes, p};
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == ChSpace || b == ChColon) b = b ^ 8'h40;
    return b;
  endfunction

  function automatic logic [7:0] cmd_char();
    case ($urandom_range(0, 3))
      0: return 8'(8'h61 + $urandom_range(0, 25));
      1: return 8'(8'h41 + $urandom_range(0, 25));
      2: return 8'(8'h30 + $urandom_range(0, 9));
      default: return word_byte();
    endcase
  endfunction

  task automatic build_random_line();
    logic [7:0] line_q[$];
    int         sel;
    int         n;
    int         nparams;
    bit         unclosed;
    sel      = $urandom_range(0, 9);
    unclosed = 1'b0;
    if (sel == 0) begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) line_q = {line_q, 8'($urandom_range(0, 255))};
    end else begin
      if ($urandom_range(0, 2) == 0) begin
        line_q = {line_q, ChColon};
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) line_q = {line_q, word_byte()};
        if (sel == 1) unclosed = 1'b1;
        else repeat ($urandom_range(1, 3)) line_q = {line_q, ChSpace};
      end else if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 2)) line_q = {line_q, ChSpace};
      end
      if (!unclosed) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) line_q = {line_q, cmd_char()};
        nparams = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 20) : $urandom_range(0, 5);
        for (int p = 0; p < nparams; p++) begin
          repeat ($urandom_range(1, 3)) line_q = {line_q, ChSpace};
          n = $urandom_range(1, 5);
          for (int i = 0; i < n; i++) line_q = {line_q, word_byte()};
        end
        if ($urandom_range(0, 1) == 1) begin
          repeat ($urandom_range(1, 2)) line_q = {line_q, ChSpace};
          line_q = {line_q, ChColon};
          n = $urandom_range(0, 8);
          for (int i = 0; i < n; i++) line_q = {line_q, 8'($urandom_range(0, 255))};
        end
        if ($urandom_range(0, 7) == 0) line_q = {line_q, ChSpace};
        if (sel == 2) begin
          n = $urandom_range(1, line_q.size());
          while (line_q.size() > n) void'(line_q.pop_back());
        end
      end
    end
    for (int i = 0; i < line_q.size(); i++) push_byte(line_q[i], i == line_q.size() - 1);
  endtask

  initial begin
    rst_ni              = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.in_byte      = 8'h00;
    in_bus.line_end     = 1'b0;
    out_bus.ready       = 1'b0;
    drain_next          = 1'b0;
    tok_phase           = PH_START;
    tok_params          = 4'd0;
    tok_field_has       = 1'b0;
    tok_overflow        = 1'b0;
    mismatch_count      = 0;
    lines_done          = 0;
    unclosed_lines      = 0;
    overflow_lines      = 0;
    drain_count         = 0;

    add_text(":p az{` b :t");
    add_text("  :z");
    add_text(":ab");
    add_text("C :");
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    add_text(":");
    drain_next = 1'b1;
    while (line_bytes.size() < 930) begin
      if (line_bytes.size() >= 650 && line_bytes.size() < 700) drain_next = 1'b1;
      build_random_line();
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    while (line_bytes.size() != 0 || in_bus.valid || expected_tags.size() != 0)
      @(negedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Checked %0d bytes in %0d lines: %0d with an unclosed prefix,",
             accepted_bytes, lines_done, unclosed_lines);
    $display("%0d past the parameter limit.", overflow_lines);
    $display("Output was held off once for a long stretch; input paused %0d times to drain.",
             drain_count);
    if (mismatch_count == 0 && expected_tags.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    bit         took;
    bit         next_valid;
    pend_byte_t nxt;
    out_item_t  pred;
    if (!rst_ni) begin
      in_bus.valid    <= 1'b0;
      in_bus.in_byte  <= 8'h00;
      in_bus.line_end <= 1'b0;
      accepted_bytes  <= 0;
      burst_left      = 0;
      gap_left        = 0;
    end else begin
      took = in_bus.valid && in_bus.ready;
      if (took) begin
        pred = tokenize_byte(in_bus.in_byte, in_bus.line_end);
        expected_tags = {expected_tags, pred};
        accepted_bytes <= accepted_bytes + 1;
        if (in_bus.line_end) begin
          lines_done++;
          if (pred.malformed) unclosed_lines++;
          if (pred.params_overflow) overflow_lines++;
        end
      end
      next_valid = in_bus.valid && !took;
      if (!next_valid) begin
        if (gap_left > 0 && hold_left == 0) begin
          gap_left--;
        end else if (line_bytes.size() != 0 &&
                     !(line_bytes[0].drain && expected_tags.size() != 0)) begin
          nxt = line_bytes.pop_front();
          if (nxt.drain) drain_count++;
          in_bus.in_byte  <= nxt.item.in_byte;
          in_bus.line_end <= nxt.item.line_end;
          next_valid = 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 40);
          burst_left--;
          if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end
      end
      in_bus.valid <= next_valid;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_bytes >= 350) begin
      hold_left <= 300;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      stall_cycle   <= 8'd0;
    end else begin
      stall_cycle <= stall_cycle + 8'd1;
      if (hold_left != 0) begin
        out_bus.ready <= 1'b0;
      end else begin
        case (stall_cycle[7:6])
          2'd0: out_bus.ready <= 1'b1;
          2'd1: out_bus.ready <= 1'($urandom_range(0, 1));
          2'd2: out_bus.ready <= (stall_cycle[1:0] == 2'd0);
          default: out_bus.ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : check_proc
    out_item_t got;
    out_item_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.out_byte        = out_bus.out_byte;
      got.field_kind      = out_bus.field_kind;
      got.is_content      = out_bus.is_content;
      got.field_first     = out_bus.field_first;
      got.param_index     = out_bus.param_index;
      got.last_of_line    = out_bus.last_of_line;
      got.param_count     = out_bus.param_count;
      got.malformed       = out_bus.malformed;
      got.params_overflow = out_bus.params_overflow;
      if (expected_tags.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result item: byte %h kind %0d", got.out_byte, got.field_kind);
      end else begin
        want = expected_tags.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Mismatch: expected byte %h kind %0d cont %b first %b idx %0d",
                     want.out_byte, want.field_kind, want.is_content, want.field_first,
                     want.param_index);
            $display("          last %b count %0d malf %b ovf %b", want.last_of_line,
                     want.param_count, want.malformed, want.params_overflow);
            $display("          got byte %h kind %0d cont %b first %b idx %0d",
                     got.out_byte, got.field_kind, got.is_content, got.field_first,
                     got.param_index);
            $display("          last %b count %0d malf %b ovf %b", got.last_of_line,
                     got.param_count, got.malformed, got.params_overflow);
          end
        end
      end
    end
  end

endmodule
